// ----- rtl/u8sv_pkg.sv -----
// ----------------------------------------------------------------------------
// u8sv_pkg
// Shared types, constants and byte-class functions for the UTF-8 stream
// validator.
// ----------------------------------------------------------------------------
package u8sv_pkg;

    // Field and state widths.
    localparam int unsigned CodeW    = 32;
    localparam int unsigned OwedW    = 3;
    localparam int unsigned NbitsW   = 3;
    localparam int unsigned ContBits = 6;

    // APB register map.
    localparam int unsigned PaddrW   = 3;
    localparam int unsigned ApbDataW = 32;

    // Register indexes (taken from paddr[2]).
    localparam logic RegAcceptExt = 1'b0;
    localparam logic RegCodeLimit = 1'b1;

    // Register reset values.
    localparam logic [CodeW-1:0] CodeLimitReset = 32'h0011_0000;

    // Low halves of code points that are noncharacters.
    localparam logic [15:0] NoncharA = 16'hFFFF;
    localparam logic [15:0] NoncharB = 16'hFFFE;

    // Payload bit counts with special meaning.
    localparam logic [NbitsW-1:0] NbitsInvalid = 3'd0;
    localparam logic [NbitsW-1:0] NbitsCont    = 3'd6;
    localparam logic [NbitsW-1:0] NbitsAscii   = 3'd7;

    // Decoder state carried from byte to byte.
    typedef struct packed {
        logic [CodeW-1:0] code_accum;
        logic [OwedW-1:0] bytes_owed;
        logic             failed;
    } t_state;

    // Configuration register contents.
    typedef struct packed {
        logic             accept_ext;
        logic [CodeW-1:0] code_limit;
    } t_cfg;

    // Count of payload bits: 7 minus the number of leading ones, 0 for FE/FF.
    function automatic logic [NbitsW-1:0] f_payload_bits(input logic [7:0] b);
        logic [NbitsW-1:0] n;
        case (b) inside
            8'b0???_????: n = 3'd7;
            8'b10??_????: n = 3'd6;
            8'b110?_????: n = 3'd5;
            8'b1110_????: n = 3'd4;
            8'b1111_0???: n = 3'd3;
            8'b1111_10??: n = 3'd2;
            8'b1111_110?: n = 3'd1;
            default:      n = 3'd0;
        endcase
        return n;
    endfunction

    // Low nbits of the byte.
    function automatic logic [7:0] f_payload(input logic [7:0] b,
                                             input logic [NbitsW-1:0] nbits);
        logic [8:0] mask;
        mask = (9'd1 << nbits) - 9'd1;
        return b & mask[7:0];
    endfunction

endpackage

// ----- rtl/u8sv_if.sv -----
// ----------------------------------------------------------------------------
// u8sv_if
// Valid/ready channel interfaces for the byte input and the result output.
// ----------------------------------------------------------------------------

// Byte input channel.
interface u8sv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       start_req;

    modport source (output valid, output data_byte, output start_req, input ready);
    modport sink   (input valid, input data_byte, input start_req, output ready);
endinterface

// Result output channel.
interface u8sv_out_if;
    logic valid;
    logic ready;
    logic stream_valid;
    logic mid_sequence;

    modport source (output valid, output stream_valid, output mid_sequence, input ready);
    modport sink   (input valid, input stream_valid, input mid_sequence, output ready);
endinterface

// ----- rtl/u8sv_apb.sv -----
// ----------------------------------------------------------------------------
// u8sv_apb
// APB register block holding the extended-mode switch and the code limit.
// ----------------------------------------------------------------------------
module u8sv_apb (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [u8sv_pkg::PaddrW-1:0]   paddr,
    input  logic [u8sv_pkg::ApbDataW-1:0] pwdata,
    output logic [u8sv_pkg::ApbDataW-1:0] prdata,
    output logic                          pready,
    output u8sv_pkg::t_cfg                o_cfg
);
    import u8sv_pkg::*;

    logic             r_accept_ext;
    logic [CodeW-1:0] r_code_limit;
    logic             w_wr;
    logic             w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign w_idx  = paddr[2];

    // Register writes in the access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accept_ext <= 1'b0;
            r_code_limit <= CodeLimitReset;
        end else if (w_wr) begin
            case (w_idx)
                RegAcceptExt: r_accept_ext <= pwdata[0];
                RegCodeLimit: r_code_limit <= pwdata[CodeW-1:0];
                default:      ;
            endcase
        end
    end

    // Read data mux.
    always_comb begin
        case (w_idx)
            RegAcceptExt: prdata = {{(ApbDataW-1){1'b0}}, r_accept_ext};
            RegCodeLimit: prdata = r_code_limit;
            default:      prdata = '0;
        endcase
    end

    assign o_cfg.accept_ext = r_accept_ext;
    assign o_cfg.code_limit = r_code_limit;

endmodule

// ----- rtl/u8sv_decode.sv -----
// ----------------------------------------------------------------------------
// u8sv_decode
// Next-state logic: classifies one byte and advances the sequence state.
// ----------------------------------------------------------------------------
module u8sv_decode (
    input  logic [7:0]       i_byte,
    input  logic             i_start,
    input  u8sv_pkg::t_state i_state,
    input  u8sv_pkg::t_cfg   i_cfg,
    output u8sv_pkg::t_state o_state
);
    import u8sv_pkg::*;

    t_state              w_cur;
    logic [NbitsW-1:0]   w_nbits;
    logic [7:0]          w_payload;
    logic                w_is_cont;
    logic [CodeW-1:0]    w_shifted;
    logic [OwedW-1:0]    w_owed_dec;
    logic                w_bad_code;

    // A start request clears the state before the byte is applied.
    assign w_cur = i_start ? '0 : i_state;

    assign w_nbits   = f_payload_bits(i_byte);
    assign w_payload = f_payload(i_byte, w_nbits);

    // Continuation check; extended mode also takes ASCII bytes.
    assign w_is_cont = (w_nbits == NbitsCont) ||
                       (i_cfg.accept_ext && (w_nbits == NbitsAscii));

    assign w_shifted  = (w_cur.code_accum << ContBits) |
                        {{(CodeW-8){1'b0}}, w_payload};
    assign w_owed_dec = w_cur.bytes_owed - OwedW'(1);

    // Finished code out of range or a noncharacter.
    assign w_bad_code = (w_shifted >= i_cfg.code_limit) ||
                        (w_shifted[15:0] == NoncharA) ||
                        (w_shifted[15:0] == NoncharB);

    always_comb begin
        o_state = w_cur;
        if (!w_cur.failed) begin
            if (w_cur.bytes_owed == '0) begin
                // Expecting a lead byte or ASCII.
                if (w_nbits == NbitsInvalid || w_nbits == NbitsCont) begin
                    o_state.failed = 1'b1;
                end else if (w_nbits != NbitsAscii) begin
                    o_state.code_accum = {{(CodeW-8){1'b0}}, w_payload};
                    o_state.bytes_owed = OwedW'(ContBits) - w_nbits;
                end
            end else if (!w_is_cont) begin
                o_state.failed = 1'b1;
            end else begin
                o_state.code_accum = w_shifted;
                o_state.bytes_owed = w_owed_dec;
                if (w_owed_dec == '0 && w_bad_code) begin
                    o_state.failed = 1'b1;
                end
            end
        end
    end

endmodule

// ----- rtl/utf8_stream_validator.sv -----
// ----------------------------------------------------------------------------
// utf8_stream_validator
// Byte-at-a-time UTF-8 well-formedness checker with sticky failure flag.
// An accepted byte waits in the input register until the result register
// is free. Throughput: one byte per cycle while the output is not stalled;
// the byte decoder between the two registers updates the sequence state.
// Reset: synchronous active-low; clears pipeline valids and sequence state,
// sets accept_extended to 0 and code_limit to 0x110000.
// ----------------------------------------------------------------------------
module utf8_stream_validator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    u8sv_in_if.sink                       i_in,
    u8sv_out_if.source                    o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [u8sv_pkg::PaddrW-1:0]   paddr,
    input  logic [u8sv_pkg::ApbDataW-1:0] pwdata,
    output logic [u8sv_pkg::ApbDataW-1:0] prdata,
    output logic                          pready
);
    import u8sv_pkg::*;

    t_cfg       w_cfg;
    t_state     r_state;
    t_state     n_state;
    logic       r_in_valid;
    logic [7:0] r_byte;
    logic       r_start;
    logic       r_out_valid;
    logic       r_stream_valid;
    logic       r_mid_sequence;
    logic       w_advance;

    // Configuration registers.
    u8sv_apb u_apb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Byte decoder and next-state logic.
    u8sv_decode u_decode (
        .i_byte  (r_byte),
        .i_start (r_start),
        .i_state (r_state),
        .i_cfg   (w_cfg),
        .o_state (n_state)
    );

    // Input register moves on when the result register is free.
    assign w_advance  = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_advance;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_byte  <= i_in.data_byte;
            r_start <= i_in.start_req;
        end
    end

    // Sequence state, updated once per transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (w_advance) begin
            r_state <= n_state;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_stream_valid <= !n_state.failed;
            r_mid_sequence <= (n_state.bytes_owed != '0);
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.stream_valid = r_stream_valid;
    assign o_out.mid_sequence = r_mid_sequence;

endmodule

// ----- tb/utf8_stream_validator_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_stream_validator_tb
// Self-checking testbench for the byte-at-a-time UTF-8 stream validator.
// A driver feeds bytes from a queue and a monitor takes the results. Both
// sides pause at random. A local decoder model predicts each result when its
// byte transaction is accepted. The run covers several register settings,
// written over APB between phases.
// ----------------------------------------------------------------------------
module utf8_stream_validator_tb;
    import u8sv_pkg::*;

    localparam int unsigned QuietLimit  = 3000;
    localparam int unsigned DrainCycles = 2;
    localparam int unsigned PrintLimit  = 30;

    typedef struct {
        logic [7:0] data_byte;
        logic       start_req;
        logic       wait_drained;
    } t_pending_byte;

    typedef struct {
        logic        stream_valid;
        logic        mid_sequence;
        int unsigned byte_no;
    } t_exp_result;

    logic                i_clk;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PaddrW-1:0]   paddr;
    logic [ApbDataW-1:0] pwdata;
    logic [ApbDataW-1:0] prdata;
    logic                pready;

    u8sv_in_if  in_ch ();
    u8sv_out_if out_ch ();

    utf8_stream_validator uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Decoder model state and its copy of the configuration registers.
    t_state            dec = '0;
    logic              cfg_ext = 1'b0;
    logic [CodeW-1:0]  cfg_limit = CodeLimitReset;

    t_pending_byte pending_bytes[$];
    t_exp_result   expected_results[$];

    logic        hold_next = 1'b0;
    int unsigned bytes_queued = 0;
    int unsigned bytes_accepted = 0;
    int unsigned results_seen = 0;
    int unsigned broken_results = 0;
    int unsigned settings_used = 1;
    int unsigned mismatches = 0;
    int unsigned quiet_cycles = 0;
    int unsigned send_gap = 0;
    int unsigned send_calm = 0;
    int unsigned stall_left = 0;
    int unsigned recv_calm = 0;

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Prints one line per mismatch, up to a limit, and counts every one.
    task automatic log_mismatch(input string what);
        mismatches++;
        if (mismatches <= PrintLimit) begin
            $display("[%0t] MISMATCH: %s", $time, what);
        end
    endtask

    // Number of payload bits a byte carries: 7 minus its leading ones.
    function automatic logic [NbitsW-1:0] count_payload_bits(input logic [7:0] b);
        int ones;
        ones = 0;
        while (ones < 8 && b[7-ones]) ones++;
        return (ones >= 7) ? NbitsInvalid : NbitsW'(7 - ones);
    endfunction

    // Advances the decoder model by one byte and returns the expected result.
    function automatic void step_decoder(input logic [7:0] b, input logic start_req,
                                         output t_exp_result res);
        logic [NbitsW-1:0] nbits;
        logic [CodeW-1:0]  payload;
        logic              is_cont;
        logic [15:0]       low_half;
        if (start_req) begin
            dec = '0;
        end
        if (!dec.failed) begin
            nbits   = count_payload_bits(b);
            payload = CodeW'(b) & ((CodeW'(1) << nbits) - CodeW'(1));
            if (dec.bytes_owed == '0) begin
                // Nothing owed: a continuation or an invalid byte breaks the stream.
                if (nbits == NbitsInvalid || nbits == NbitsCont) begin
                    dec.failed = 1'b1;
                end else if (nbits != NbitsAscii) begin
                    dec.code_accum = payload;
                    dec.bytes_owed = OwedW'(6 - nbits);
                end
            end else begin
                is_cont = (nbits == NbitsCont) || (cfg_ext && nbits >= NbitsCont);
                if (!is_cont) begin
                    dec.failed = 1'b1;
                end else begin
                    dec.code_accum = (dec.code_accum << ContBits) | payload;
                    dec.bytes_owed = dec.bytes_owed - OwedW'(1);
                    // A finished code is judged against the limit and noncharacters.
                    if (dec.bytes_owed == '0) begin
                        low_half = dec.code_accum[15:0];
                        if (dec.code_accum >= cfg_limit || low_half == NoncharA ||
                            low_half == NoncharB) begin
                            dec.failed = 1'b1;
                        end
                    end
                end
            end
        end
        res.stream_valid = !dec.failed;
        res.mid_sequence = (dec.bytes_owed != '0);
    endfunction

    // Random pause length: mostly none or short, a few long, with calm stretches.
    function automatic int unsigned pick_pause(inout int unsigned calm_left);
        int unsigned r;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2) begin
            calm_left = $urandom_range(20, 80);
            return 0;
        end
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Byte driver: presents queued bytes and predicts each accepted one.
    always @(posedge i_clk) begin : drive_bytes
        t_pending_byte nxt;
        t_exp_result   res;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            dec = '0;
            send_gap = 0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                step_decoder(in_ch.data_byte, in_ch.start_req, res);
                res.byte_no = bytes_accepted;
                expected_results.push_back(res);
                bytes_accepted++;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_ch.valid <= 1'b0;
                end else if (pending_bytes.size() > 0 &&
                             (!pending_bytes[0].wait_drained ||
                              expected_results.size() == 0)) begin
                    nxt = pending_bytes.pop_front();
                    in_ch.valid     <= 1'b1;
                    in_ch.data_byte <= nxt.data_byte;
                    in_ch.start_req <= nxt.start_req;
                    send_gap = pick_pause(send_calm);
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: stalls at random and checks each result transaction.
    always @(posedge i_clk) begin : collect_results
        t_exp_result want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    log_mismatch($sformatf("result with no byte outstanding (valid=%b mid=%b)",
                                           out_ch.stream_valid, out_ch.mid_sequence));
                end else begin
                    want = expected_results.pop_front();
                    if (!want.stream_valid) broken_results++;
                    if (out_ch.stream_valid !== want.stream_valid) begin
                        log_mismatch($sformatf("byte %0d: stream_valid %b, expected %b",
                                               want.byte_no, out_ch.stream_valid,
                                               want.stream_valid));
                    end
                    if (out_ch.mid_sequence !== want.mid_sequence) begin
                        log_mismatch($sformatf("byte %0d: mid_sequence %b, expected %b",
                                               want.byte_no, out_ch.mid_sequence,
                                               want.mid_sequence));
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
                stall_left = pick_pause(recv_calm);
            end
        end
    end

    // Counts cycles without any transaction on either channel or the APB port.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Watchdog.
    initial begin
        wait (quiet_cycles >= QuietLimit);
        $display("Timeout: no transaction for %0d cycles", QuietLimit);
        $display("Mismatches found");
        $finish;
    end

    // Writes a register over APB, updates the model copy, then reads it back.
    task automatic write_reg(input logic idx, input logic [ApbDataW-1:0] value);
        logic [ApbDataW-1:0] want;
        want = (idx == RegAcceptExt) ? ApbDataW'(value[0]) : value;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == RegAcceptExt) begin
            cfg_ext = value[0];
        end else begin
            cfg_limit = value;
        end
        @(posedge i_clk);
        psel <= 1'b1;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== want) begin
            log_mismatch($sformatf("register %0d read back %h, expected %h", idx, prdata, want));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Waits until every queued byte is sent and every result has come back.
    task automatic wait_until_drained();
        do @(negedge i_clk);
        while (pending_bytes.size() != 0 || in_ch.valid || expected_results.size() != 0);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    task automatic queue_byte(input logic [7:0] b, input logic start_req);
        t_pending_byte item;
        item.data_byte    = b;
        item.start_req    = start_req;
        item.wait_drained = hold_next;
        pending_bytes.push_back(item);
        hold_next = 1'b0;
        bytes_queued++;
    endtask

    // Random traffic: mostly well-formed sequences with random payload, some
    // truncated, some noise, lone continuations and invalid bytes.
    task automatic queue_random_traffic(input int unsigned n_bytes);
        logic [7:0]  seq[6];
        int unsigned target;
        int unsigned len;
        int unsigned keep;
        int unsigned r;
        int unsigned k;
        logic        start_req;
        target = bytes_queued + n_bytes;
        while (bytes_queued < target) begin
            start_req = ($urandom_range(0, 99) < 30);
            r = $urandom_range(0, 99);
            if (r < 80) begin
                k = $urandom_range(0, 99);
                len = (k < 30) ? 1 : (k < 50) ? 2 : (k < 70) ? 3 : (k < 85) ? 4 :
                      (k < 93) ? 5 : 6;
                if (len == 1) begin
                    seq[0] = 8'($urandom_range(0, 127));
                end else begin
                    seq[0] = (8'hFF << (8 - len)) | (8'($urandom()) & (8'hFF >> (len + 1)));
                    for (k = 1; k < len; k++) begin
                        // In extended mode an ASCII byte may stand in for a continuation.
                        seq[k] = (cfg_ext && $urandom_range(0, 4) == 0) ?
                                 8'($urandom_range(0, 127)) :
                                 (8'h80 | 8'($urandom_range(0, 63)));
                    end
                    // Now and then force the low 16 bits to a noncharacter.
                    if (len >= 3 && $urandom_range(0, 7) == 0) begin
                        seq[len-1] = 8'hBE | 8'($urandom_range(0, 1));
                        seq[len-2] = 8'hBF;
                        seq[len-3] = seq[len-3] | 8'h0F;
                    end
                end
                keep = (r >= 70 && len > 1) ? $urandom_range(1, len - 1) : len;
                for (k = 0; k < keep; k++) begin
                    queue_byte(seq[k], (k == 0) ? start_req : ($urandom_range(0, 49) == 0));
                end
            end else if (r < 90) begin
                queue_byte(8'($urandom_range(0, 255)), start_req);
            end else if ($urandom_range(0, 1) == 0) begin
                queue_byte(8'hFE | 8'($urandom_range(0, 1)), start_req);
            end else begin
                queue_byte(8'h80 | 8'($urandom_range(0, 63)), start_req);
            end
        end
    endtask

    // Main sequence: reset, then phases under different register settings.
    initial begin
        i_rst_n         = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        in_ch.valid     = 1'b0;
        in_ch.data_byte = '0;
        in_ch.start_req = 1'b0;
        out_ch.ready    = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: ASCII extremes, lone continuation, invalid bytes.
        queue_byte(8'h00, 1'b1); queue_byte(8'h7F, 1'b0); queue_byte(8'h80, 1'b0);
        queue_byte(8'hFE, 1'b1); queue_byte(8'hFF, 1'b1);
        // Two and three byte sequences, and four byte sequences on either side of the code limit.
        queue_byte(8'hC2, 1'b1); queue_byte(8'hA9, 1'b0);
        queue_byte(8'hE2, 1'b0); queue_byte(8'h82, 1'b0); queue_byte(8'hAC, 1'b0);
        queue_byte(8'hF4, 1'b0); queue_byte(8'h8F, 1'b0); queue_byte(8'hBF, 1'b0);
        queue_byte(8'hBD, 1'b0);
        queue_byte(8'hF4, 1'b0); queue_byte(8'h90, 1'b0); queue_byte(8'h80, 1'b0);
        queue_byte(8'h80, 1'b0);
        // A byte after a failure is ignored.
        queue_byte(8'h41, 1'b0);
        // Noncharacter, missing continuation, and a restart in mid-sequence.
        queue_byte(8'hEF, 1'b1); queue_byte(8'hBF, 1'b0); queue_byte(8'hBF, 1'b0);
        queue_byte(8'hC2, 1'b1); queue_byte(8'h41, 1'b0);
        queue_byte(8'hC2, 1'b1); queue_byte(8'h41, 1'b1);
        queue_random_traffic(120);
        hold_next = 1'b1;
        queue_random_traffic(120);
        wait_until_drained();

        // Extended mode with a code limit above every code that a sequence can build.
        write_reg(RegAcceptExt, 32'd1);
        write_reg(RegCodeLimit, 32'h8000_0000);
        settings_used++;
        queue_byte(8'hFD, 1'b1);
        for (int i = 0; i < 4; i++) queue_byte(8'hBF, 1'b0);
        queue_byte(8'hBD, 1'b0);
        queue_byte(8'hC2, 1'b1); queue_byte(8'h41, 1'b0);
        queue_random_traffic(130);
        wait_until_drained();

        // Zero limit: every finished multi-byte code fails.
        write_reg(RegAcceptExt, 32'd0);
        write_reg(RegCodeLimit, 32'd0);
        settings_used++;
        queue_random_traffic(100);
        wait_until_drained();

        // Extended mode with a random limit.
        write_reg(RegAcceptExt, 32'd1);
        write_reg(RegCodeLimit, (32'($urandom()) & 32'h7FFF_FFFF) >> $urandom_range(0, 20));
        settings_used++;
        queue_random_traffic(120);
        wait_until_drained();

        // Back to the reset values.
        write_reg(RegAcceptExt, 32'd0);
        write_reg(RegCodeLimit, CodeLimitReset);
        settings_used++;
        queue_random_traffic(100);
        wait_until_drained();
        repeat (5) @(posedge i_clk);

        $display("Checked %0d results for %0d bytes under %0d register settings;",
                 results_seen, bytes_accepted, settings_used);
        $display("%0d of those results flagged a broken stream.", broken_results);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
